// ===== rtl/core/apdd_pkg.sv =====
// ----------------------------------------------------------------------------
// apdd_pkg: shared types and constants of the pressure drop detector
// Timer and pressure limits, register indexes and the config and state records.
// ----------------------------------------------------------------------------
package apdd_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned TimerW  = 16;
  localparam int unsigned PressW  = 11;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [TimerW-1:0]  TimerLimit = 16'd63000;
  localparam logic [SampleW-1:0] PressMin   = 16'd500;
  localparam logic [SampleW-1:0] PressMax   = 16'd1500;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMemoPeriod   = 3'd0,
    CfgLowThreshold = 3'd1,
    CfgLowHyst      = 3'd2,
    CfgDropThresh   = 3'd3,
    CfgDropHyst     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0]        memo_period;
    logic [15:0]        low_threshold;
    logic [7:0]         low_hyst;
    logic signed [15:0] drop_threshold;
    logic [7:0]         drop_hyst;
  } apdd_cfg_t;

  typedef struct packed {
    logic [TimerW-1:0] timer;
    logic [PressW-1:0] ref_press;
    logic              low_flag;
    logic              drop_flag;
    logic              memo_last;
    logic              memo_before_last;
  } apdd_state_t;

endpackage

// ===== rtl/core/atmospheric_pressure_drop_detector.sv =====
// ----------------------------------------------------------------------------
// atmospheric_pressure_drop_detector: outside-air pressure drop detector
// One result word per pressure sample word, with hysteresis flags.
// ----------------------------------------------------------------------------
// Each input word is one tick carrying a pressure sample; each tick returns one
// result word with the low-pressure flag, the drop flag, their OR, the
// memorized reference pressure (500..1500) and the tick timer. A word is taken
// into an input register, evaluated combinationally against the state
// registers and written to the output register, so the block sustains one word
// per clock, set by the state update loop; the output register only blocks new
// words while a result is stalled. The user must write configuration through
// the cfg channel while the block is idle; the block does not enforce it.
module atmospheric_pressure_drop_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i,
  // sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] pressure_sample
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [0] pressure_unfavourable, [1] low_pressure_flag,
                                      // [2] pressure_drop_flag, [13:3] memorized_pressure,
                                      // [29:14] memo_timer, [31:30] zero
);

  apdd_pkg::apdd_cfg_t          cfg_q;
  apdd_pkg::apdd_state_t        state_q, state_d;
  logic                         in_valid_q;
  logic [apdd_pkg::SampleW-1:0] sample_q;
  logic                         out_valid_q;
  logic [29:0]                  out_word_q;
  logic                         advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (apdd_pkg::cfg_idx_e'(cfg_addr_i))
        apdd_pkg::CfgMemoPeriod:   cfg_q.memo_period    <= cfg_data_i;
        apdd_pkg::CfgLowThreshold: cfg_q.low_threshold  <= cfg_data_i;
        apdd_pkg::CfgLowHyst:      cfg_q.low_hyst       <= cfg_data_i[7:0];
        apdd_pkg::CfgDropThresh:   cfg_q.drop_threshold <= cfg_data_i;
        apdd_pkg::CfgDropHyst:     cfg_q.drop_hyst      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      sample_q <= s_axis_tdata;
    end
  end

  apdd_eval u_eval (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .sample_i (sample_q),
    .state_o  (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{timer:            '0,
                   ref_press:        apdd_pkg::PressMin[apdd_pkg::PressW-1:0],
                   low_flag:         1'b0,
                   drop_flag:        1'b0,
                   memo_last:        1'b0,
                   memo_before_last: 1'b0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q <= {state_d.timer, state_d.ref_press, state_d.drop_flag,
                     state_d.low_flag, state_d.low_flag | state_d.drop_flag};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_word_q};

endmodule

// ===== rtl/core/apdd_eval.sv =====
// ----------------------------------------------------------------------------
// apdd_eval: next-state logic for one pressure tick
// Timer update, memorize decision, reference clamp and both hysteresis flags.
// ----------------------------------------------------------------------------
module apdd_eval (
  input  apdd_pkg::apdd_cfg_t          cfg_i,
  input  apdd_pkg::apdd_state_t        state_i,
  input  logic [apdd_pkg::SampleW-1:0] sample_i,
  output apdd_pkg::apdd_state_t        state_o
);

  logic [apdd_pkg::TimerW-1:0]  timer_nxt;
  logic [19:0]                  memo_lim;
  logic                         memorize;
  logic [apdd_pkg::SampleW-1:0] ref_sel;
  logic [apdd_pkg::PressW-1:0]  ref_nxt;
  logic [16:0]                  low_clr_lvl;
  logic signed [17:0]           drop_val;
  logic signed [17:0]           drop_set_lvl;
  logic signed [17:0]           drop_clr_lvl;
  logic                         low_nxt;
  logic                         drop_nxt;

  always_comb begin
    if (state_i.memo_last && !state_i.memo_before_last) begin
      timer_nxt = '0;
    end else if (state_i.timer >= apdd_pkg::TimerLimit) begin
      timer_nxt = apdd_pkg::TimerLimit;
    end else begin
      timer_nxt = state_i.timer + 16'd1;
    end
  end

  // period * 10 as (p << 3) + (p << 1), full width
  assign memo_lim = {1'b0, cfg_i.memo_period, 3'b000} + {3'b000, cfg_i.memo_period, 1'b0};
  assign memorize = {4'd0, timer_nxt} >= memo_lim;

  assign ref_sel = memorize ? sample_i : {5'd0, state_i.ref_press};

  always_comb begin
    if (ref_sel < apdd_pkg::PressMin) begin
      ref_nxt = apdd_pkg::PressMin[apdd_pkg::PressW-1:0];
    end else if (ref_sel > apdd_pkg::PressMax) begin
      ref_nxt = apdd_pkg::PressMax[apdd_pkg::PressW-1:0];
    end else begin
      ref_nxt = ref_sel[apdd_pkg::PressW-1:0];
    end
  end

  assign low_clr_lvl = {1'b0, cfg_i.low_threshold} + {9'd0, cfg_i.low_hyst};

  always_comb begin
    if ({1'b0, sample_i} >= low_clr_lvl) begin
      low_nxt = 1'b0;
    end else if (sample_i <= cfg_i.low_threshold) begin
      low_nxt = 1'b1;
    end else begin
      low_nxt = state_i.low_flag;
    end
  end

  assign drop_val     = {7'd0, ref_nxt} - {2'd0, sample_i};
  assign drop_set_lvl = {{2{cfg_i.drop_threshold[15]}}, cfg_i.drop_threshold};
  assign drop_clr_lvl = drop_set_lvl - {10'd0, cfg_i.drop_hyst};

  // clear test has priority when the levels overlap
  always_comb begin
    if (drop_val <= drop_clr_lvl) begin
      drop_nxt = 1'b0;
    end else if (drop_val >= drop_set_lvl) begin
      drop_nxt = 1'b1;
    end else begin
      drop_nxt = state_i.drop_flag;
    end
  end

  always_comb begin
    state_o.timer            = timer_nxt;
    state_o.ref_press        = ref_nxt;
    state_o.low_flag         = low_nxt;
    state_o.drop_flag        = drop_nxt;
    state_o.memo_last        = memorize;
    state_o.memo_before_last = state_i.memo_last;
  end

endmodule

// ===== rtl/core/apdd_checker.sv =====
// ----------------------------------------------------------------------------
// apdd_checker: port-level checks of the pressure drop detector
// Watches the result stream and the input ready and is bound to the top level.
// ----------------------------------------------------------------------------
module apdd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // with the output register empty the input side never blocks
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_ref_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[13:3] >= 11'd500 && m_axis_tdata[13:3] <= 11'd1500)
    else $error("memorized pressure out of range");

  a_timer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[29:14] <= 16'd63000)
    else $error("timer above limit");

  a_unfav: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[0] == (m_axis_tdata[1] | m_axis_tdata[2]))
    else $error("unfavourable flag mismatch");

endmodule

bind atmospheric_pressure_drop_detector apdd_checker u_apdd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
